[src/rti_pkg.sv]
// ============================================================================
// rti_pkg
// Shared constants and types for the ray/triangle intersection pipeline.
// ============================================================================
package rti_pkg;

    // Default number format of vector components (signed Q11.10)
    localparam int FRAC_BITS_DEF      = 10;
    localparam int COMPONENT_BITS_DEF = 21;

    // Fixed port widths
    localparam int VEC_W  = 63;
    localparam int DIST_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Tolerance register widths and reset values
    localparam int FACE_TOL_W = 20;
    localparam int EDGE_TOL_W = 30;
    localparam logic [FACE_TOL_W-1:0] FACE_TOL_RESET = 20'd10;
    localparam logic [EDGE_TOL_W-1:0] EDGE_TOL_RESET = 30'd10737;

    // Distance is Q16.16; the divider yields this many quotient bits
    localparam int T_FRAC   = 16;
    localparam int QUO_BITS = 32;

    // Split point of the wide edge triple product
    localparam int ESPL = 24;

    // Register index (byte address bits [2+:1])
    typedef enum logic [ADDR_W-3:0] {
        REG_FACE_TOL = 1'b0,
        REG_EDGE_TOL = 1'b1
    } reg_idx_t;

endpackage

[src/rti_div_pipe.sv]
// ============================================================================
// rti_div_pipe
// Pipelined restoring divider: one quotient bit per stage, saturation flag.
// ============================================================================
module rti_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int QUO_W = rti_pkg::QUO_BITS
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             sat,
    output logic             rem_nz
);
    import rti_pkg::*;

    localparam int W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [W-1:0]     rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             sat_reg [QUO_W+1];

    // entry: quotient would not fit in QUO_W bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= W'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= (W'(num) >= (W'(den) << QUO_W));
        end
    end

    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_step
        localparam int B = QUO_W - j;
        logic [W-1:0] trial;
        logic         take;

        assign trial = W'(den_reg[j-1]) << B;
        assign take  = (rem_reg[j-1] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (take ? (QUO_W'(1) << B) : '0);
                sat_reg[j] <= sat_reg[j-1];
            end
        end
    end

    assign quo    = quo_reg[QUO_W];
    assign sat    = sat_reg[QUO_W];
    assign rem_nz = |rem_reg[QUO_W];

endmodule

[src/ray_triangle_intersection.sv]
// ============================================================================
// ray_triangle_intersection
// Pipelined ray / triangle plane-and-edge intersection test.
// ============================================================================
// One beat in, one beat out, one beat per clock when the output is not
// stalled. The pipeline is built around the 33-stage restoring dividers
// (one quotient bit per stage) that produce t and the hit point. The whole
// pipeline moves together: it advances whenever the output register is
// empty or being taken, so in_stall follows out_stall only while a result
// is held. Tolerances are written through the APB port (facing at 0x0, edge
// at 0x4) and must only change while no beat is in flight.
module ray_triangle_intersection #(
    parameter int FRAC_BITS      = rti_pkg::FRAC_BITS_DEF,
    parameter int COMPONENT_BITS = rti_pkg::COMPONENT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rti_pkg::ADDR_W-1:0]  paddr,
    input  logic [rti_pkg::DATA_W-1:0]  pwdata,
    output logic [rti_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input beat
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rti_pkg::VEC_W-1:0]   ray_origin,
    input  logic [rti_pkg::VEC_W-1:0]   ray_direction,
    input  logic [rti_pkg::VEC_W-1:0]   vertex_a,
    input  logic [rti_pkg::VEC_W-1:0]   vertex_b,
    input  logic [rti_pkg::VEC_W-1:0]   vertex_c,
    input  logic [rti_pkg::VEC_W-1:0]   face_normal,
    // output beat
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        plane_hit,
    output logic                        hit,
    output logic [rti_pkg::DIST_W-1:0]  hit_distance,
    output logic [rti_pkg::VEC_W-1:0]   hit_point
);
    import rti_pkg::*;

    // ---------------------------------------------------------------- widths
    localparam int C   = COMPONENT_BITS;
    localparam int VW  = 3 * C;
    localparam int PDW = 2 * C;          // normal * direction term
    localparam int D1W = 2 * C + 2;      // normal . direction
    localparam int POW = 2 * C + 1;      // normal * (origin - a) term
    localparam int DSS = 2 * C + 3;      // signed plane distance
    localparam int DSW = 2 * C + 1;      // distance once known >= 0
    localparam int DNW = 2 * C;          // denominator -(n . d)
    localparam int SPL = (DSW + 1) / 2;  // split of distance for |d| products
    localparam int SHW = DSW - SPL;
    localparam int NW  = DSW + C;        // distance * |dir|
    localparam int TNW = DSW + T_FRAC;   // distance << 16
    localparam int DIV_LAT = QUO_BITS + 1;
    localparam int OFW = C + 3;
    localparam int PSW = C + 4;
    localparam int XW  = 2 * C + 2;      // cross product term
    localparam int MW  = 2 * C + 3;      // cross product component
    localparam int LPW = ESPL + 1 + C;
    localparam int HPW = MW - ESPL + C;
    localparam int LSW = LPW + 2;
    localparam int HSW = HPW + 2;
    localparam int EW  = ((3 * C + 6) > 50) ? (3 * C + 6) : 50;
    localparam int FW  = ((D1W > 33) ? D1W : 33) + 1;

    // tolerance scaling into the units of the dot / triple products
    localparam int FK  = 2 * FRAC_BITS - 20;
    localparam int FKL = (FK >= 0) ? FK : 0;
    localparam int FKR = (FK < 0) ? -FK : 0;
    localparam int EK  = 3 * FRAC_BITS - 30;
    localparam int EKL = (EK >= 0) ? EK : 0;
    localparam int EKR = (EK < 0) ? -EK : 0;
    localparam logic [FW-1:0] FRND = (FW'(1) << FKR) - FW'(1);

    // packed geometry: org, dir, a, b, c, normal
    localparam int GW    = 6 * VW;
    localparam int G_ORG = 0;
    localparam int G_DIR = VW;
    localparam int G_VA  = 2 * VW;
    localparam int G_N   = 5 * VW;

    localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

    function automatic logic signed [C-1:0] comp(input logic [GW-1:0] g, input int base);
        return signed'(g[base +: C]);
    endfunction

    // --------------------------------------------------------- configuration
    logic [FACE_TOL_W-1:0] face_tol_reg;
    logic [EDGE_TOL_W-1:0] edge_tol_reg;
    reg_idx_t              cfg_idx;
    logic                  cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_tol_reg <= FACE_TOL_RESET;
            edge_tol_reg <= EDGE_TOL_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FACE_TOL: face_tol_reg <= pwdata[FACE_TOL_W-1:0];
                REG_EDGE_TOL: edge_tol_reg <= pwdata[EDGE_TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FACE_TOL: prdata = DATA_W'(face_tol_reg);
            REG_EDGE_TOL: prdata = DATA_W'(edge_tol_reg);
            default:      prdata = '0;
        endcase
    end

    // thresholds; facing rounds the magnitude up when scaled down
    logic        [FW-1:0] fmag;
    logic signed [FW-1:0] fthr;
    logic        [EW-1:0] emag;
    logic signed [EW-1:0] ethr;

    always_comb
    begin
        if (FK >= 0)
            fmag = FW'(face_tol_reg) << FKL;
        else
            fmag = (FW'(face_tol_reg) + FRND) >> FKR;
        fthr = -signed'(fmag);
        emag = (EW'(edge_tol_reg) << EKL) >> EKR;
        ethr = -signed'(emag);
    end

    // ------------------------------------------------------- flow control
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------------------------------------------- stage 1: products
    logic [GW-1:0]         geo_in;
    logic signed [PDW-1:0] pd_next [3];
    logic signed [POW-1:0] po_next [3];

    assign geo_in = {face_normal[VW-1:0], vertex_c[VW-1:0], vertex_b[VW-1:0],
                     vertex_a[VW-1:0], ray_direction[VW-1:0], ray_origin[VW-1:0]};

    always_comb
    begin
        logic signed [C-1:0] n;
        logic signed [C:0]   diff;
        for (int i = 0; i < 3; i++)
        begin
            n          = comp(geo_in, G_N + i * C);
            diff       = (C+1)'(comp(geo_in, G_ORG + i * C))
                       - (C+1)'(comp(geo_in, G_VA + i * C));
            pd_next[i] = n * comp(geo_in, G_DIR + i * C);
            po_next[i] = n * diff;
        end
    end

    logic                  s1_valid_reg;
    logic [GW-1:0]         s1_geo_reg;
    logic signed [PDW-1:0] s1_pd_reg [3];
    logic signed [POW-1:0] s1_po_reg [3];

    // ------------------------------------------------------ stage 2: dot sums
    logic                  s2_valid_reg;
    logic [GW-1:0]         s2_geo_reg;
    logic signed [D1W-1:0] s2_d1_reg;
    logic signed [DSS-1:0] s2_dist_reg;

    // ---------------------------------- stage 3: plane test, |dir| products
    logic                  plane_next;
    logic [SPL+C-1:0]      mlo_next [3];
    logic [SHW+C-1:0]      mhi_next [3];
    logic [DSW-1:0]        distu;

    assign distu = DSW'(s2_dist_reg);

    always_comb
    begin
        logic signed [C-1:0] b;
        logic [C-1:0]        babs;
        plane_next = !(FW'(s2_d1_reg) > fthr) && s2_d1_reg[D1W-1] && !s2_dist_reg[DSS-1];
        for (int i = 0; i < 3; i++)
        begin
            b           = comp(s2_geo_reg, G_DIR + i * C);
            babs        = b[C-1] ? C'(-b) : C'(b);
            mlo_next[i] = distu[SPL-1:0] * babs;
            mhi_next[i] = distu[DSW-1:SPL] * babs;
        end
    end

    logic                  s3_valid_reg;
    logic                  s3_plane_reg;
    logic [GW-1:0]         s3_geo_reg;
    logic [DNW-1:0]        s3_den_reg;
    logic [DSW-1:0]        s3_dist_reg;
    logic [SPL+C-1:0]      s3_mlo_reg [3];
    logic [SHW+C-1:0]      s3_mhi_reg [3];

    // ------------------------------------------ stage 4: divider numerators
    logic                  s4_valid_reg;
    logic                  s4_plane_reg;
    logic [GW-1:0]         s4_geo_reg;
    logic [DNW-1:0]        s4_den_reg;
    logic [DSW-1:0]        s4_dist_reg;
    logic [NW-1:0]         s4_num_reg [3];

    // --------------------------------- sideband alongside the divider stages
    logic                  sb_valid_reg [DIV_LAT];
    logic                  sb_plane_reg [DIV_LAT];
    logic [GW-1:0]         sb_geo_reg   [DIV_LAT];

    logic [QUO_BITS-1:0]   t_quo;
    logic                  t_sat;
    logic                  t_nz;
    logic [QUO_BITS-1:0]   p_quo [3];
    logic                  p_sat [3];
    logic                  p_nz  [3];

    rti_div_pipe #(
        .NUM_W (TNW),
        .DEN_W (DNW),
        .QUO_W (QUO_BITS)
    ) u_div_t (
        .clk    (clk),
        .en     (adv),
        .num    (TNW'(s4_dist_reg) << T_FRAC),
        .den    (s4_den_reg),
        .quo    (t_quo),
        .sat    (t_sat),
        .rem_nz (t_nz)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div_p
        rti_div_pipe #(
            .NUM_W (NW),
            .DEN_W (DNW),
            .QUO_W (QUO_BITS)
        ) u_div_p (
            .clk    (clk),
            .en     (adv),
            .num    (s4_num_reg[i]),
            .den    (s4_den_reg),
            .quo    (p_quo[i]),
            .sat    (p_sat[i]),
            .rem_nz (p_nz[i])
        );
    end

    // ------------------------------------ stage 5: distance and hit point
    // point = origin + floor(dist * dir / den), clamped to the component range
    logic [DIST_W-1:0]     tq_next;
    logic signed [C-1:0]   pt_next [3];
    logic [GW-1:0]         geo_dv;

    assign geo_dv  = sb_geo_reg[DIV_LAT-1];
    assign tq_next = t_sat ? '1 : DIST_W'(t_quo);

    always_comb
    begin
        logic signed [C-1:0]   b;
        logic signed [OFW-1:0] qs;
        logic signed [OFW-1:0] off;
        logic signed [PSW-1:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            b   = comp(geo_dv, G_DIR + i * C);
            qs  = signed'(OFW'(p_quo[i][C:0]));
            off = b[C-1] ? -(qs + OFW'(p_nz[i])) : qs;
            sum = PSW'(comp(geo_dv, G_ORG + i * C)) + PSW'(off);
            if (p_sat[i] || (|p_quo[i][QUO_BITS-1:C+1]))
                pt_next[i] = b[C-1] ? CMIN : CMAX;
            else if (sum > PSW'(CMAX))
                pt_next[i] = CMAX;
            else if (sum < PSW'(CMIN))
                pt_next[i] = CMIN;
            else
                pt_next[i] = C'(sum);
        end
    end

    logic                  s5_valid_reg;
    logic                  s5_plane_reg;
    logic [GW-1:0]         s5_geo_reg;
    logic [DIST_W-1:0]     s5_tq_reg;
    logic signed [C-1:0]   s5_pt_reg [3];

    // ------------------------------------------- stage 6: cross product terms
    // edge k runs from vertex k to vertex k+1; d = vertex k - point
    logic signed [XW-1:0]  pa_next [3][3];
    logic signed [XW-1:0]  pb_next [3][3];

    always_comb
    begin
        logic signed [C:0] ev [3];
        logic signed [C:0] dv [3];
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ev[j] = (C+1)'(comp(s5_geo_reg, G_VA + ((k + 1) % 3) * VW + j * C))
                      - (C+1)'(comp(s5_geo_reg, G_VA + k * VW + j * C));
                dv[j] = (C+1)'(comp(s5_geo_reg, G_VA + k * VW + j * C))
                      - (C+1)'(s5_pt_reg[j]);
            end
            for (int i = 0; i < 3; i++)
            begin
                pa_next[k][i] = dv[(i + 1) % 3] * ev[(i + 2) % 3];
                pb_next[k][i] = dv[(i + 2) % 3] * ev[(i + 1) % 3];
            end
        end
    end

    logic                  s6_valid_reg;
    logic                  s6_plane_reg;
    logic [VW-1:0]         s6_n_reg;
    logic [DIST_W-1:0]     s6_tq_reg;
    logic signed [C-1:0]   s6_pt_reg [3];
    logic signed [XW-1:0]  s6_pa_reg [3][3];
    logic signed [XW-1:0]  s6_pb_reg [3][3];

    // ------------------------------------------------ stage 7: cross product
    logic                  s7_valid_reg;
    logic                  s7_plane_reg;
    logic [VW-1:0]         s7_n_reg;
    logic [DIST_W-1:0]     s7_tq_reg;
    logic signed [C-1:0]   s7_pt_reg [3];
    logic signed [MW-1:0]  s7_m_reg [3][3];

    // ------------------------------ stage 8: split products with the normal
    logic signed [LPW-1:0] lo_next [3][3];
    logic signed [HPW-1:0] hi_next [3][3];

    always_comb
    begin
        logic signed [C-1:0] n;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n             = signed'(s7_n_reg[i * C +: C]);
                lo_next[k][i] = signed'({1'b0, s7_m_reg[k][i][ESPL-1:0]}) * n;
                hi_next[k][i] = signed'(s7_m_reg[k][i][MW-1:ESPL]) * n;
            end
        end
    end

    logic                  s8_valid_reg;
    logic                  s8_plane_reg;
    logic [DIST_W-1:0]     s8_tq_reg;
    logic signed [C-1:0]   s8_pt_reg [3];
    logic signed [LPW-1:0] s8_lo_reg [3][3];
    logic signed [HPW-1:0] s8_hi_reg [3][3];

    // ------------------------------------------------ stage 9: partial sums
    logic                  s9_valid_reg;
    logic                  s9_plane_reg;
    logic [DIST_W-1:0]     s9_tq_reg;
    logic signed [C-1:0]   s9_pt_reg [3];
    logic signed [LSW-1:0] s9_ls_reg [3];
    logic signed [HSW-1:0] s9_hs_reg [3];

    // ---------------------------------- stage 10: edge compare, result beat
    logic                  in_tri;

    always_comb
    begin
        logic signed [EW-1:0] total;
        in_tri = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            total = (EW'(s9_hs_reg[k]) <<< ESPL) + EW'(s9_ls_reg[k]);
            if (total < ethr)
                in_tri = 1'b0;
        end
    end

    logic                  plane_hit_reg;
    logic                  hit_reg;
    logic [DIST_W-1:0]     hit_distance_reg;
    logic [VEC_W-1:0]      hit_point_reg;

    // ---------------------------------------------------- valid bits (reset)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++)
                sb_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            sb_valid_reg[0] <= s4_valid_reg;
            for (int s = 1; s < DIV_LAT; s++)
                sb_valid_reg[s] <= sb_valid_reg[s-1];
            s5_valid_reg    <= sb_valid_reg[DIV_LAT-1];
            s6_valid_reg    <= s5_valid_reg;
            s7_valid_reg    <= s6_valid_reg;
            s8_valid_reg    <= s7_valid_reg;
            s9_valid_reg    <= s8_valid_reg;
            out_valid_reg   <= s9_valid_reg;
        end
    end

    // -------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_geo_reg <= geo_in;
            for (int i = 0; i < 3; i++)
            begin
                s1_pd_reg[i] <= pd_next[i];
                s1_po_reg[i] <= po_next[i];
            end

            // stage 2
            s2_geo_reg  <= s1_geo_reg;
            s2_d1_reg   <= D1W'(s1_pd_reg[0]) + D1W'(s1_pd_reg[1]) + D1W'(s1_pd_reg[2]);
            s2_dist_reg <= DSS'(s1_po_reg[0]) + DSS'(s1_po_reg[1]) + DSS'(s1_po_reg[2]);

            // stage 3
            s3_plane_reg <= plane_next;
            s3_geo_reg   <= s2_geo_reg;
            s3_den_reg   <= DNW'(-s2_d1_reg);
            s3_dist_reg  <= distu;
            for (int i = 0; i < 3; i++)
            begin
                s3_mlo_reg[i] <= mlo_next[i];
                s3_mhi_reg[i] <= mhi_next[i];
            end

            // stage 4
            s4_plane_reg <= s3_plane_reg;
            s4_geo_reg   <= s3_geo_reg;
            s4_den_reg   <= s3_den_reg;
            s4_dist_reg  <= s3_dist_reg;
            for (int i = 0; i < 3; i++)
                s4_num_reg[i] <= (NW'(s3_mhi_reg[i]) << SPL) + NW'(s3_mlo_reg[i]);

            // divider sideband
            sb_plane_reg[0] <= s4_plane_reg;
            sb_geo_reg[0]   <= s4_geo_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                sb_plane_reg[s] <= sb_plane_reg[s-1];
                sb_geo_reg[s]   <= sb_geo_reg[s-1];
            end

            // stage 5
            s5_plane_reg <= sb_plane_reg[DIV_LAT-1];
            s5_geo_reg   <= geo_dv;
            s5_tq_reg    <= tq_next;
            for (int i = 0; i < 3; i++)
                s5_pt_reg[i] <= pt_next[i];

            // stage 6
            s6_plane_reg <= s5_plane_reg;
            s6_n_reg     <= s5_geo_reg[G_N +: VW];
            s6_tq_reg    <= s5_tq_reg;
            for (int i = 0; i < 3; i++)
                s6_pt_reg[i] <= s5_pt_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s6_pa_reg[k][i] <= pa_next[k][i];
                    s6_pb_reg[k][i] <= pb_next[k][i];
                end
            end

            // stage 7
            s7_plane_reg <= s6_plane_reg;
            s7_n_reg     <= s6_n_reg;
            s7_tq_reg    <= s6_tq_reg;
            for (int i = 0; i < 3; i++)
                s7_pt_reg[i] <= s6_pt_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                    s7_m_reg[k][i] <= MW'(s6_pa_reg[k][i]) - MW'(s6_pb_reg[k][i]);
            end

            // stage 8
            s8_plane_reg <= s7_plane_reg;
            s8_tq_reg    <= s7_tq_reg;
            for (int i = 0; i < 3; i++)
                s8_pt_reg[i] <= s7_pt_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s8_lo_reg[k][i] <= lo_next[k][i];
                    s8_hi_reg[k][i] <= hi_next[k][i];
                end
            end

            // stage 9
            s9_plane_reg <= s8_plane_reg;
            s9_tq_reg    <= s8_tq_reg;
            for (int i = 0; i < 3; i++)
                s9_pt_reg[i] <= s8_pt_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                s9_ls_reg[k] <= LSW'(s8_lo_reg[k][0]) + LSW'(s8_lo_reg[k][1])
                              + LSW'(s8_lo_reg[k][2]);
                s9_hs_reg[k] <= HSW'(s8_hi_reg[k][0]) + HSW'(s8_hi_reg[k][1])
                              + HSW'(s8_hi_reg[k][2]);
            end

            // result: everything zero without a plane hit
            plane_hit_reg    <= s9_plane_reg;
            hit_reg          <= s9_plane_reg & in_tri;
            hit_distance_reg <= s9_plane_reg ? s9_tq_reg : '0;
            hit_point_reg    <= (s9_plane_reg & in_tri)
                              ? VEC_W'({s9_pt_reg[2], s9_pt_reg[1], s9_pt_reg[0]})
                              : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign plane_hit    = plane_hit_reg;
    assign hit          = hit_reg;
    assign hit_distance = hit_distance_reg;
    assign hit_point    = hit_point_reg;

endmodule

[tb/tb_ray_triangle_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersection
// Self-checking bench for the ray/triangle intersection pipeline. A scoreboard
// predicts plane hit, inside test, distance and hit point for every accepted
// beat and checks the results in order, under random idling and back pressure
// and across several tolerance settings written over APB.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersection;
    import rti_pkg::*;

    localparam int  CB       = 21;
    localparam int  DRAIN    = 60;      // longer than the pipeline latency
    localparam longint CMAX  = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN  = -(longint'(1) << (CB - 1));

    typedef struct {
        logic [VEC_W-1:0] org, dir, va, vb, vc, nrm;
    } ray_tri_t;

    typedef struct {
        logic              plane_hit;
        logic              hit;
        logic [DIST_W-1:0] t_dist;
        logic [VEC_W-1:0]  point;
    } isect_t;

    // ------------------------------------------------------------------------
    // Scoreboard: intersection predictor plus queue of pending results
    // ------------------------------------------------------------------------
    class isect_scoreboard;
        isect_t pending_q[$];
        logic [FACE_TOL_W-1:0] face_tol = FACE_TOL_RESET;
        logic [EDGE_TOL_W-1:0] edge_tol = EDGE_TOL_RESET;
        int mismatches = 0;
        int checked    = 0;
        int plane_hits = 0;
        int tri_hits   = 0;

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function longint clampc(longint v);
            return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
        endfunction

        function longint comp(logic [VEC_W-1:0] v, int i);
            return longint'($signed(v[i*CB +: CB]));
        endfunction

        // start + floor(a*b/c), saturated; a >= 0, c > 0
        function longint step_along(longint start, longint a, longint b, longint c);
            longint qa, ra;
            if (b == 0)
                return start;
            qa = a / c;
            ra = a % c;
            if (qa >= (longint'(1) << (CB + 1)))
                return clampc(b > 0 ? (longint'(1) << CB) : -(longint'(1) << CB));
            return clampc(start + qa * b + fdiv(ra * b, c));
        endfunction

        // ((v - p) x e) . n < thr, exact in 128 bits
        function bit outside_edge(longint v[3], longint p[3], longint e[3],
                                  longint n[3], longint thr);
            longint d[3], m[3];
            logic signed [127:0] tp;
            for (int i = 0; i < 3; i++)
                d[i] = v[i] - p[i];
            m[0] = d[1] * e[2] - d[2] * e[1];
            m[1] = d[2] * e[0] - d[0] * e[2];
            m[2] = d[0] * e[1] - d[1] * e[0];
            tp = 128'sd0;
            for (int i = 0; i < 3; i++)
                tp += 128'(signed'(m[i])) * 128'(signed'(n[i]));
            return tp < 128'(signed'(thr));
        endfunction

        function void note_beat(ray_tri_t b);
            longint o[3], dr[3], a[3], vb[3], vc[3], n[3], pt[3];
            longint e0[3], e1[3], e2[3];
            longint ndd, pdist, den, tq, ethr;
            logic [VEC_W-1:0] pk;
            bit in_tri;
            isect_t r;
            r = '{1'b0, 1'b0, '0, '0};
            for (int i = 0; i < 3; i++)
            begin
                o[i]  = comp(b.org, i);
                dr[i] = comp(b.dir, i);
                a[i]  = comp(b.va, i);
                vb[i] = comp(b.vb, i);
                vc[i] = comp(b.vc, i);
                n[i]  = comp(b.nrm, i);
            end
            ndd   = n[0]*dr[0] + n[1]*dr[1] + n[2]*dr[2];
            pdist = n[0]*(o[0]-a[0]) + n[1]*(o[1]-a[1]) + n[2]*(o[2]-a[2]);
            // facing test and behind-start test
            if (!(ndd > -longint'(face_tol) || ndd >= 0) && pdist >= 0)
            begin
                den = -ndd;
                tq  = (pdist * 65536) / den;
                if (tq > 64'hFFFF_FFFF)
                    tq = 64'hFFFF_FFFF;
                for (int i = 0; i < 3; i++)
                begin
                    pt[i] = step_along(o[i], pdist, dr[i], den);
                    e0[i] = vb[i] - a[i];
                    e1[i] = vc[i] - vb[i];
                    e2[i] = a[i] - vc[i];
                end
                ethr   = -longint'(edge_tol);
                in_tri = !outside_edge(a, pt, e0, n, ethr)
                      && !outside_edge(vb, pt, e1, n, ethr)
                      && !outside_edge(vc, pt, e2, n, ethr);
                pk = '0;
                for (int i = 0; i < 3; i++)
                    pk[i*CB +: CB] = pt[i][CB-1:0];
                r.plane_hit = 1'b1;
                r.hit       = in_tri;
                r.t_dist    = tq[DIST_W-1:0];
                r.point     = in_tri ? pk : '0;
            end
            pending_q.push_back(r);
        endfunction

        function void check_beat(isect_t got);
            isect_t e;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing pending");
                return;
            end
            e = pending_q.pop_front();
            checked++;
            plane_hits += e.plane_hit;
            tri_hits   += e.hit;
            if (got.plane_hit !== e.plane_hit || got.hit !== e.hit ||
                got.t_dist !== e.t_dist || got.point !== e.point)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR beat %0d: exp ph=%0b hit=%0b t=%h p=%h got ph=%0b hit=%0b t=%h p=%h",
                             checked, e.plane_hit, e.hit, e.t_dist, e.point,
                             got.plane_hit, got.hit, got.t_dist, got.point);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_stall;
    logic [VEC_W-1:0] ray_origin = '0, ray_direction = '0, vertex_a = '0;
    logic [VEC_W-1:0] vertex_b = '0, vertex_c = '0, face_normal = '0;
    logic out_valid, out_stall = 1'b0;
    logic plane_hit, hit;
    logic [DIST_W-1:0] hit_distance;
    logic [VEC_W-1:0] hit_point;

    ray_triangle_intersection u_dut (.*);

    always #6 clk = ~clk;

    isect_scoreboard sb = new();
    bit in_taken = 1'b0;
    bit quiet    = 1'b0;   // phases with no idling on either side
    int beats_in = 0;

    // Monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        in_taken = in_valid && !in_stall;
        if (in_taken)
        begin
            sb.note_beat('{ray_origin, ray_direction, vertex_a, vertex_b,
                           vertex_c, face_normal});
            beats_in++;
        end
        if (out_valid && !out_stall)
            sb.check_beat('{plane_hit, hit, hit_distance, hit_point});
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back pressure: bursts of stall, mostly short
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!quiet && $urandom_range(0, 3) == 0)
            stall_left = gap_len();
        out_stall <= (stall_left > 0);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(ray_tri_t b);
        int g;
        ray_origin    = b.org;
        ray_direction = b.dir;
        vertex_a      = b.va;
        vertex_b      = b.vb;
        vertex_c      = b.vc;
        face_normal   = b.nrm;
        in_valid      = 1'b1;
        do
            @(negedge clk);
        while (!in_taken);
        g = gap_len();
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_FACE_TOL)
            sb.face_tol = val[FACE_TOL_W-1:0];
        else
            sb.edge_tol = val[EDGE_TOL_W-1:0];
    endtask

    // Idle point: everything drained plus the pipeline depth
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    function logic [VEC_W-1:0] vec(longint x, longint y, longint z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function longint rs(int n);
        return longint'($urandom_range(0, 2 * n)) - n;
    endfunction

    // Mostly real scenes aimed near the triangle; the rest raw noise
    function ray_tri_t scene();
        ray_tri_t b;
        longint a[3], p[3], q[3], n[3], d[3], t[3];
        longint s, nd;
        if ($urandom_range(0, 99) < 15)
        begin
            b.org = VEC_W'({$urandom, $urandom});
            b.dir = VEC_W'({$urandom, $urandom});
            b.va  = VEC_W'({$urandom, $urandom});
            b.vb  = VEC_W'({$urandom, $urandom});
            b.vc  = VEC_W'({$urandom, $urandom});
            b.nrm = VEC_W'({$urandom, $urandom});
            return b;
        end
        for (int i = 0; i < 3; i++)
        begin
            a[i] = rs(4096);
            p[i] = rs(4096);
            q[i] = rs(4096);
            d[i] = rs(2048);
        end
        n[0] = ((p[1]-a[1])*(q[2]-a[2]) - (p[2]-a[2])*(q[1]-a[1])) >>> 8;
        n[1] = ((p[2]-a[2])*(q[0]-a[0]) - (p[0]-a[0])*(q[2]-a[2])) >>> 8;
        n[2] = ((p[0]-a[0])*(q[1]-a[1]) - (p[1]-a[1])*(q[0]-a[0])) >>> 8;
        nd = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
        s  = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++)
        begin
            if (nd > 0)
                d[i] = -d[i];
            t[i] = (a[i] + p[i] + q[i]) / 3 + rs(2048) - d[i] * s;
        end
        b = '{vec(t[0], t[1], t[2]), vec(d[0], d[1], d[2]), vec(a[0], a[1], a[2]),
              vec(p[0], p[1], p[2]), vec(q[0], q[1], q[2]), vec(n[0], n[1], n[2])};
        return b;
    endfunction

    // Directed beats on a flat triangle in the z=0 plane, normal +z
    task automatic directed();
        logic [VEC_W-1:0] ta, tb, tc, nz, down;
        ta   = vec(0, 0, 0);
        tb   = vec(4096, 0, 0);
        tc   = vec(0, 4096, 0);
        nz   = vec(0, 0, 1024);
        down = vec(0, 0, -1024);
        send_beat('{vec(1024, 1024, 2048), down, ta, tb, tc, nz});     // clean hit
        send_beat('{vec(1024, 1024, 0), down, ta, tb, tc, nz});        // t of zero
        send_beat('{vec(1024, 1024, -2048), down, ta, tb, tc, nz});    // behind start
        send_beat('{vec(1024, 1024, 2048), vec(1024, 0, 0), ta, tb, tc, nz}); // parallel
        send_beat('{vec(1024, 1024, 2048), vec(0, 0, 1024), ta, tb, tc, nz}); // back face
        send_beat('{vec(4096, 4096, 2048), down, ta, tb, tc, nz});     // outside
        send_beat('{vec(2048, 0, 2048), down, ta, tb, tc, nz});        // on an edge
        send_beat('{vec(2048, -1, 2048), down, ta, tb, tc, nz});       // just past edge
        send_beat('{vec(1024, 1024, CMAX), vec(0, 0, -1), ta, tb, tc, nz}); // t saturates
        send_beat('{vec(1, 1, 1), vec(0, 0, -1), ta, tb, tc, vec(0, 0, 10)});  // at tolerance
        send_beat('{vec(1, 1, 1), vec(0, 0, -1), ta, tb, tc, vec(0, 0, 9)});   // inside tolerance
        send_beat('{'0, '0, '0, '0, '0, '0});
        send_beat('{'1, '1, '1, '1, '1, '1});
        send_beat('{vec(CMAX, CMAX, CMAX), vec(CMAX, CMAX, CMAX), vec(CMAX, CMAX, CMAX),
                    vec(CMAX, CMAX, CMAX), vec(CMAX, CMAX, CMAX), vec(CMAX, CMAX, CMAX)});
        send_beat('{vec(CMIN, CMIN, CMIN), vec(CMAX, CMAX, CMAX), vec(CMAX, CMAX, CMAX),
                    vec(CMIN, CMAX, CMIN), vec(CMAX, CMIN, CMIN), vec(CMIN, CMIN, CMIN)});
        send_beat('{vec(CMIN, 0, CMAX), vec(CMAX, 1, -1), ta, tb, tc, vec(CMIN, CMIN, CMIN)});
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: five tolerance settings, directed beats in the first two
    // ------------------------------------------------------------------------
    initial
    begin
        logic [DATA_W-1:0] ftol[5], etol[5];
        ftol = '{32'd10, 32'd0, 32'hF_FFFF, 32'd0, 32'd0};
        etol = '{32'd10737, 32'd0, 32'h3FFF_FFFF, 32'd0, 32'd0};
        ftol[3] = $urandom_range(0, 2000);
        etol[3] = $urandom_range(0, 1 << 20);
        ftol[4] = $urandom_range(0, 32'hF_FFFF);
        etol[4] = $urandom & 32'h3FFF_FFFF;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(REG_FACE_TOL, ftol[ph]);
            write_reg(REG_EDGE_TOL, etol[ph]);
            quiet = (ph == 2);
            if (ph < 2)
                directed();
            repeat (350) send_beat(scene());
        end
        quiet = 1'b0;
        drain();
        $display("Covered %0d beats over 5 tolerance settings: %0d plane hits, %0d triangle hits.",
                 beats_in, sb.plane_hits, sb.tri_hits);
        $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("ray_triangle_intersection verification clean");
        else
            $display("ray_triangle_intersection verification failed");
        $finish;
    end

    // Watchdog well above the slowest legal run
    initial
    begin
        #40ms;
        $display("ray_triangle_intersection verification failed");
        $finish;
    end

endmodule
